// File: hdl/cti_pkg.sv
// ----------------------------------------------------------------------------
// cti_pkg
// Shared types, widths and codes of the calibration table interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package cti_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int IDX_IN_W    = 6;

    // field widths
    localparam int FREQ_W = 24;
    localparam int CORR_W = 16;
    localparam int OP_W   = 2;
    localparam int SRC_W  = 2;
    localparam int ENTRY_W = FREQ_W + CORR_W;

    // the interpolated quotient never exceeds the correction span
    localparam int DIV_STEPS = CORR_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef logic [FREQ_W-1:0]        freq_t;
    typedef logic signed [CORR_W-1:0] corr_t;

    // opcodes
    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    // result source codes
    localparam logic [SRC_W-1:0] SRC_NORMAL = 2'd0;
    localparam logic [SRC_W-1:0] SRC_EMPTY  = 2'd1;
    localparam logic [SRC_W-1:0] SRC_BELOW  = 2'd2;
    localparam logic [SRC_W-1:0] SRC_ABOVE  = 2'd3;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESOLVE,
        ST_MUL,
        ST_DIV,
        ST_FINISH,
        ST_OUTPUT
    } state_t;

endpackage

`default_nettype wire

// File: hdl/cti_if.sv
// ----------------------------------------------------------------------------
// cti_if
// Request and response channels of the calibration table interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

interface cti_req_if
    import cti_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     opcode;
    logic [IDX_IN_W-1:0] entry_index;
    freq_t               entry_frequency;
    corr_t               entry_correction;
    logic                entry_valid;
    freq_t               query_frequency;

    modport source (
        output valid, opcode, entry_index, entry_frequency, entry_correction,
               entry_valid, query_frequency,
        input  ready
    );

    modport sink (
        input  valid, opcode, entry_index, entry_frequency, entry_correction,
               entry_valid, query_frequency,
        output ready
    );
endinterface

interface cti_rsp_if
    import cti_pkg::*;
;
    logic             valid;
    logic             ready;
    corr_t            correction;
    logic [SRC_W-1:0] src;

    modport source (
        output valid, correction, src,
        input  ready
    );

    modport sink (
        input  valid, correction, src,
        output ready
    );
endinterface

`default_nettype wire

// File: hdl/cti_ram.sv
// ----------------------------------------------------------------------------
// cti_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cti_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: hdl/calibration_table_interpolator.sv
// ----------------------------------------------------------------------------
// calibration_table_interpolator
// Calibration point table with bracket search and linear interpolation.
// ----------------------------------------------------------------------------
//
//  channel  dir  word                                         accepted when
//  -------  ---  -------------------------------------------  -------------
//  req      in   opcode, entry index/frequency/correction/     valid & ready
//                valid flag, query frequency
//  rsp      out  correction, src                              valid & ready
//
//  Write, clear and unused opcodes are taken while idle. A query scans the
//  whole table through the RAM read port, then resolves and loads the
//  output register. An interpolated query adds a multiply step, a
//  restoring divider and a signed fix-up step before the output load.
//  Reset clears the set flags at once; the RAM holds no reset value.
//  A result waiting on rsp stalls only the end of the next query.
// ----------------------------------------------------------------------------
`default_nettype none

module calibration_table_interpolator
    import cti_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    cti_req_if.sink   req,
    cti_rsp_if.source rsp
);

    localparam int EXT_W = ((IDX_W > IDX_IN_W) ? IDX_W : IDX_IN_W) + 1;

    state_t state_reg, state_next;

    // table storage
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic                   ram_we;
    logic                   ram_re;
    logic [IDX_W-1:0]       ram_raddr;
    logic [ENTRY_W-1:0]     ram_rdata;
    logic [EXT_W-1:0]       idx_ext;
    logic                   idx_in_range;
    logic                   req_accept;

    // scan
    logic [IDX_W:0]   addr_reg;
    logic             pend_reg;
    logic [IDX_W-1:0] pidx_reg;
    freq_t            q_reg;
    freq_t            pt_freq;
    corr_t            pt_corr;
    logic             have_first_reg, have_lo_reg, have_hi_reg;
    corr_t            first_corr_reg, last_corr_reg, lo_corr_reg, hi_corr_reg;
    freq_t            lo_freq_reg, hi_freq_reg;

    // arithmetic
    logic signed [CORR_W:0]   dy;
    logic [CORR_W-1:0]        abs_dy_reg;
    logic                     neg_reg;
    freq_t                    dq_reg, dx_reg;
    logic [ENTRY_W-1:0]       prod;
    freq_t                    rem_reg;
    logic [CORR_W-1:0]        low_reg;
    logic [FREQ_W:0]          div_shift;
    logic [FREQ_W:0]          div_trial;
    logic [CNT_W-1:0]         cnt_reg;
    logic signed [CORR_W:0]   quo_signed;
    logic signed [CORR_W:0]   interp_sum;

    // result
    corr_t            res_corr_reg;
    logic [SRC_W-1:0] res_src_reg;
    logic             out_valid_reg;
    corr_t            out_corr_reg;
    logic [SRC_W-1:0] out_src_reg;
    logic             out_load;

    assign req_accept   = req.valid && req.ready;
    assign idx_ext      = EXT_W'(req.entry_index);
    assign idx_in_range = idx_ext < EXT_W'(TABLE_DEPTH);
    assign ram_we       = req_accept && (req.opcode == OP_WRITE) && idx_in_range;

    cti_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_ext[IDX_W-1:0]),
        .wdata ({req.entry_frequency, req.entry_correction}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign pt_freq = ram_rdata[ENTRY_W-1:CORR_W];
    assign pt_corr = ram_rdata[CORR_W-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_accept && (req.opcode == OP_QUERY))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if ((addr_reg == (IDX_W+1)'(TABLE_DEPTH)) && !pend_reg)
                begin
                    state_next = ST_RESOLVE;
                end
            end
            ST_RESOLVE:
            begin
                if (have_lo_reg && have_hi_reg && (lo_freq_reg != hi_freq_reg))
                begin
                    state_next = ST_MUL;
                end
                else
                begin
                    state_next = ST_OUTPUT;
                end
            end
            ST_MUL:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_OUTPUT;
            end
            ST_OUTPUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        req.ready = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = addr_reg[IDX_W-1:0];
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
            end
            ST_SCAN:
            begin
                ram_re = (addr_reg != (IDX_W+1)'(TABLE_DEPTH));
            end
            ST_OUTPUT:
            begin
                out_load = !out_valid_reg || rsp.ready;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    // signed span and its magnitude
    assign dy = {hi_corr_reg[CORR_W-1], hi_corr_reg} - {lo_corr_reg[CORR_W-1], lo_corr_reg};

    // restoring divide step
    assign prod      = ENTRY_W'(abs_dy_reg * dq_reg);
    assign div_shift = {rem_reg, low_reg[CORR_W-1]};
    assign div_trial = div_shift - {1'b0, dx_reg};

    // final signed fix-up
    assign quo_signed = neg_reg ? -$signed({1'b0, low_reg}) : $signed({1'b0, low_reg});
    assign interp_sum = $signed({lo_corr_reg[CORR_W-1], lo_corr_reg}) + quo_signed;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            addr_reg       <= '0;
            pend_reg       <= 1'b0;
            have_first_reg <= 1'b0;
            have_lo_reg    <= 1'b0;
            have_hi_reg    <= 1'b0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // table writes and clear
            if (req_accept && (req.opcode == OP_CLEAR))
            begin
                valid_reg <= '0;
            end
            else if (ram_we)
            begin
                valid_reg[idx_ext[IDX_W-1:0]] <= req.entry_valid;
            end

            // query start
            if (req_accept && (req.opcode == OP_QUERY))
            begin
                addr_reg       <= '0;
                pend_reg       <= 1'b0;
                have_first_reg <= 1'b0;
                have_lo_reg    <= 1'b0;
                have_hi_reg    <= 1'b0;
            end

            // scan pointer and bracket flags
            if (state_reg == ST_SCAN)
            begin
                pend_reg <= ram_re;
                if (ram_re)
                begin
                    addr_reg <= addr_reg + 1'b1;
                end
                if (pend_reg && valid_reg[pidx_reg])
                begin
                    have_first_reg <= 1'b1;
                    if (pt_freq <= q_reg)
                    begin
                        have_lo_reg <= 1'b1;
                    end
                    if (pt_freq >= q_reg)
                    begin
                        have_hi_reg <= 1'b1;
                    end
                end
            end

            // divider step count
            if (state_reg == ST_MUL)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == ST_DIV)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end

            // output register
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (req_accept && (req.opcode == OP_QUERY))
        begin
            q_reg <= req.query_frequency;
        end

        // bracket capture
        if (state_reg == ST_SCAN)
        begin
            pidx_reg <= addr_reg[IDX_W-1:0];
            if (pend_reg && valid_reg[pidx_reg])
            begin
                if (!have_first_reg)
                begin
                    first_corr_reg <= pt_corr;
                end
                last_corr_reg <= pt_corr;
                if (pt_freq <= q_reg)
                begin
                    lo_freq_reg <= pt_freq;
                    lo_corr_reg <= pt_corr;
                end
                if ((pt_freq >= q_reg) && !have_hi_reg)
                begin
                    hi_freq_reg <= pt_freq;
                    hi_corr_reg <= pt_corr;
                end
            end
        end

        // pick result case, set up interpolation operands
        if (state_reg == ST_RESOLVE)
        begin
            res_src_reg  <= SRC_NORMAL;
            res_corr_reg <= lo_corr_reg;
            if (!have_lo_reg && !have_hi_reg)
            begin
                res_src_reg  <= SRC_EMPTY;
                res_corr_reg <= '0;
            end
            else if (!have_lo_reg)
            begin
                res_src_reg  <= SRC_BELOW;
                res_corr_reg <= first_corr_reg;
            end
            else if (!have_hi_reg)
            begin
                res_src_reg  <= SRC_ABOVE;
                res_corr_reg <= last_corr_reg;
            end
            neg_reg    <= dy[CORR_W];
            abs_dy_reg <= dy[CORR_W] ? CORR_W'(-dy) : dy[CORR_W-1:0];
            dq_reg     <= q_reg - lo_freq_reg;
            dx_reg     <= hi_freq_reg - lo_freq_reg;
        end

        // product loads the divider; high part is already below the divisor
        if (state_reg == ST_MUL)
        begin
            rem_reg <= prod[ENTRY_W-1:CORR_W];
            low_reg <= prod[CORR_W-1:0];
        end
        else if (state_reg == ST_DIV)
        begin
            if (!div_trial[FREQ_W])
            begin
                rem_reg <= div_trial[FREQ_W-1:0];
            end
            else
            begin
                rem_reg <= div_shift[FREQ_W-1:0];
            end
            low_reg <= {low_reg[CORR_W-2:0], !div_trial[FREQ_W]};
        end

        if (state_reg == ST_FINISH)
        begin
            res_corr_reg <= interp_sum[CORR_W-1:0];
        end

        if (out_load)
        begin
            out_corr_reg <= res_corr_reg;
            out_src_reg  <= res_src_reg;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.correction = out_corr_reg;
    assign rsp.src        = out_src_reg;

    // checks
    a_query_starts_scan: assert property (
        @(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && (req.opcode == OP_QUERY))
            |=> (state_reg == ST_SCAN) && (addr_reg == '0) && !have_first_reg)
        else $error("query did not start a fresh scan");

    a_clear_drops_flags: assert property (
        @(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && (req.opcode == OP_CLEAR)) |=> (valid_reg == '0))
        else $error("clear left set flags");

    a_interp_has_brackets: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL)
            |-> have_lo_reg && have_hi_reg && (dx_reg != '0) && (res_src_reg == SRC_NORMAL))
        else $error("interpolation without distinct brackets");

    a_no_load_over_word: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || rsp.ready) && (state_reg == ST_OUTPUT))
        else $error("output word overwritten");

endmodule

`default_nettype wire
